FILE: rtl/itc_pkg.sv
// itc_pkg: shared types and constants of the three-counter interval timer
// used by itc_counter and interval_timer_three_counter, no dependencies

package itc_pkg;

  localparam int unsigned NUM_COUNTERS = 3;
  localparam int unsigned SLOTS        = 3;

  localparam logic [7:0] PORT_C0   = 8'h40;
  localparam logic [7:0] PORT_C1   = 8'h41;
  localparam logic [7:0] PORT_C2   = 8'h42;
  localparam logic [7:0] PORT_CTRL = 8'h43;
  localparam logic [7:0] PORT_SYS  = 8'h61;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] MODE_ONESHOT = 3'd0;
  localparam logic [2:0] MODE_RATE    = 3'd2;
  localparam logic [2:0] MODE_MAX     = 3'd5;
  localparam logic [1:0] RW_LATCH     = 2'd0;
  localparam logic [1:0] RW_BOTH      = 2'd3;
  localparam logic [1:0] ID_READBACK  = 2'd3;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic tick;
    logic cnt_wr;
    logic ctl_wr;
    logic snap_rd;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic       expire;
    logic [7:0] rd_byte;
    logic       out_level;
  } rsp_t;

endpackage

FILE: rtl/itc_counter.sv
// itc_counter: one 16-bit binary counter, modes 0 and 2, count load and latch
// depends on itc_pkg

module itc_counter (
  input  logic             clk,
  input  logic             rst_n,
  input  itc_pkg::cmd_t    cmd,
  input  logic [7:0]       data_byte,
  input  logic [15:0]      tick_n,
  input  logic             gate,
  output itc_pkg::rsp_t    rsp
);

  logic [15:0] count_r, count_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic        mode_two_r, mode_two_nxt;
  logic        programmed_r, programmed_nxt;
  logic        running_r, running_nxt;
  logic        out_level_r, out_level_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        load_phase_r, load_phase_nxt;
  logic [15:0] snap_r, snap_nxt;
  logic        snap_full_r, snap_full_nxt;
  logic        snap_phase_r, snap_phase_nxt;

  logic [16:0] left;
  logic [16:0] remain;
  logic        hit;
  logic [15:0] new_load;
  logic [1:0]  rw;
  logic [2:0]  mode;

  assign left     = (count_r == 16'd0) ? 17'h10000 : {1'b0, count_r};
  assign hit      = running_r && (left <= {1'b0, tick_n});
  assign remain   = left - {1'b0, tick_n};
  assign new_load = {data_byte, low_r};
  assign rw       = data_byte[5:4];
  assign mode     = data_byte[3:1];

  always_comb begin
    count_nxt      = count_r;
    reload_nxt     = reload_r;
    mode_two_nxt   = mode_two_r;
    programmed_nxt = programmed_r;
    running_nxt    = running_r;
    out_level_nxt  = out_level_r;
    low_nxt        = low_r;
    load_phase_nxt = load_phase_r;
    snap_nxt       = snap_r;
    snap_full_nxt  = snap_full_r;
    snap_phase_nxt = snap_phase_r;
    rsp.ok         = 1'b1;
    rsp.expire     = hit;
    rsp.rd_byte    = 8'd0;
    rsp.out_level  = out_level_r;
    priority if (cmd.tick) begin
      if (running_r) begin
        if (!hit) begin
          count_nxt = remain[15:0];
        end else if (!mode_two_r) begin
          count_nxt     = 16'd0;
          running_nxt   = 1'b0;
          out_level_nxt = 1'b1;
        end else begin
          count_nxt = reload_r;
        end
      end
    end else if (cmd.cnt_wr) begin
      if (!programmed_r) begin
        rsp.ok = 1'b0;
      end else if (!load_phase_r) begin
        low_nxt        = data_byte;
        load_phase_nxt = 1'b1;
      end else begin
        reload_nxt     = new_load;
        load_phase_nxt = 1'b0;
        low_nxt        = 8'd0;
        snap_full_nxt  = 1'b0;
        snap_phase_nxt = 1'b0;
        if (!mode_two_r) begin
          count_nxt   = new_load;
          running_nxt = 1'b1;
          if (gate) begin
            out_level_nxt = 1'b0;
          end
        end else if (new_load == 16'd1) begin
          rsp.ok = 1'b0;
        end else if (gate && !running_r) begin
          count_nxt     = new_load;
          running_nxt   = 1'b1;
          out_level_nxt = 1'b1;
        end
      end
    end else if (cmd.ctl_wr) begin
      if (rw == itc_pkg::RW_LATCH) begin
        if (snap_full_r) begin
          rsp.ok = 1'b0;
        end else begin
          snap_full_nxt  = 1'b1;
          snap_nxt       = count_r;
          snap_phase_nxt = 1'b0;
        end
      end else if (rw != itc_pkg::RW_BOTH ||
                   (mode != itc_pkg::MODE_ONESHOT && mode != itc_pkg::MODE_RATE)) begin
        rsp.ok = 1'b0;
      end else begin
        mode_two_nxt   = (mode == itc_pkg::MODE_RATE);
        programmed_nxt = 1'b1;
        low_nxt        = 8'd0;
        load_phase_nxt = 1'b0;
        out_level_nxt  = (mode == itc_pkg::MODE_RATE);
      end
    end else if (cmd.snap_rd) begin
      if (!snap_full_r) begin
        rsp.ok = 1'b0;
      end else if (!snap_phase_r) begin
        snap_phase_nxt = 1'b1;
        rsp.rd_byte    = snap_r[7:0];
      end else begin
        snap_full_nxt  = 1'b0;
        snap_phase_nxt = 1'b0;
        rsp.rd_byte    = snap_r[15:8];
      end
    end else begin
      // idle cycle, state holds
      rsp.ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= 16'd0;
      reload_r     <= 16'd0;
      mode_two_r   <= 1'b0;
      programmed_r <= 1'b0;
      running_r    <= 1'b0;
      out_level_r  <= 1'b0;
      low_r        <= 8'd0;
      load_phase_r <= 1'b0;
      snap_r       <= 16'd0;
      snap_full_r  <= 1'b0;
      snap_phase_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      reload_r     <= reload_nxt;
      mode_two_r   <= mode_two_nxt;
      programmed_r <= programmed_nxt;
      running_r    <= running_nxt;
      out_level_r  <= out_level_nxt;
      low_r        <= low_nxt;
      load_phase_r <= load_phase_nxt;
      snap_r       <= snap_nxt;
      snap_full_r  <= snap_full_nxt;
      snap_phase_r <= snap_phase_nxt;
    end
  end

endmodule

FILE: rtl/interval_timer_three_counter.sv
// interval_timer_three_counter: top level, input beat register, port decode,
// system control port and result register; depends on itc_pkg, itc_counter
// data path: an input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while the result side accepts; out_tready low stalls the input
// reset: synchronous active-low rst_n returns all counters, latches and port 0x61
// bits to their power-on values; no clearing pass, ready right after reset

module interval_timer_three_counter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // operation[1:0], port[9:2], data[17:10], tick_count[33:18], zero pad
  input  logic [itc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_data[7:0], irq_zero[8], error[9], zero pad
  output logic [itc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic        in_valid_r;
  logic [1:0]  op_r;
  logic [7:0]  port_r;
  logic [7:0]  data_r;
  logic [15:0] tick_r;

  logic        out_valid_r;
  logic [7:0]  rd_r, rd_nxt;
  logic        irq_r, irq_nxt;
  logic        err_r, err_nxt;

  logic        spk_r, spk_nxt;
  logic        refresh_r, refresh_nxt;
  logic        gate2_r, gate2_nxt;

  logic        advance;
  logic [1:0]  cnt_id;
  logic [1:0]  ctl_id;
  logic        ctl_valid;

  itc_pkg::cmd_t cmd [itc_pkg::SLOTS];
  itc_pkg::rsp_t rsp [itc_pkg::SLOTS];

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign cnt_id    = port_r[1:0] - itc_pkg::PORT_C0[1:0];
  assign ctl_id    = data_r[7:6];
  assign ctl_valid = (ctl_id != itc_pkg::ID_READBACK) &&
                     (data_r[3:1] <= itc_pkg::MODE_MAX) && !data_r[0] &&
                     (32'(ctl_id) < itc_pkg::NUM_COUNTERS);

  genvar gi;
  generate
    for (gi = 0; gi < itc_pkg::SLOTS; gi++) begin : g_cnt
      always_comb begin
        cmd[gi]         = '0;
        cmd[gi].tick    = advance && (op_r == itc_pkg::OP_TICK);
        cmd[gi].cnt_wr  = advance && (op_r == itc_pkg::OP_WRITE) &&
                          (port_r == itc_pkg::PORT_C0 || port_r == itc_pkg::PORT_C1 ||
                           port_r == itc_pkg::PORT_C2) && (cnt_id == 2'(gi));
        cmd[gi].ctl_wr  = advance && (op_r == itc_pkg::OP_WRITE) &&
                          (port_r == itc_pkg::PORT_CTRL) && ctl_valid && (ctl_id == 2'(gi));
        cmd[gi].snap_rd = advance && (op_r == itc_pkg::OP_READ) &&
                          (port_r == itc_pkg::PORT_C0) && (gi == 0);
      end
      if (gi < itc_pkg::NUM_COUNTERS) begin : g_on
        itc_counter u_cnt (
          .clk       (clk),
          .rst_n     (rst_n),
          .cmd       (cmd[gi]),
          .data_byte (data_r),
          .tick_n    (tick_r),
          .gate      ((gi == 2) ? gate2_r : 1'b1),
          .rsp       (rsp[gi])
        );
      end else begin : g_off
        assign rsp[gi] = '0;
      end
    end
  endgenerate

  always_comb begin
    rd_nxt      = 8'd0;
    irq_nxt     = 1'b0;
    err_nxt     = 1'b0;
    spk_nxt     = spk_r;
    refresh_nxt = refresh_r;
    gate2_nxt   = gate2_r;
    unique case (op_r)
      itc_pkg::OP_READ: begin
        if (port_r == itc_pkg::PORT_C0) begin
          err_nxt = !rsp[0].ok;
          rd_nxt  = rsp[0].ok ? rsp[0].rd_byte : 8'd0;
        end else if (port_r == itc_pkg::PORT_SYS) begin
          refresh_nxt = !refresh_r;
          rd_nxt      = {2'b00, rsp[2].out_level, !refresh_r, 2'b00, spk_r, gate2_r};
        end else begin
          err_nxt = 1'b1;
        end
      end
      itc_pkg::OP_WRITE: begin
        if (port_r == itc_pkg::PORT_C0 || port_r == itc_pkg::PORT_C1 ||
            port_r == itc_pkg::PORT_C2) begin
          err_nxt = !rsp[cnt_id].ok;
        end else if (port_r == itc_pkg::PORT_CTRL) begin
          err_nxt = !(ctl_valid && rsp[ctl_id].ok);
        end else if (port_r == itc_pkg::PORT_SYS) begin
          spk_nxt   = data_r[1];
          gate2_nxt = data_r[0];
          err_nxt   = (data_r[0] != gate2_r);
        end else begin
          err_nxt = 1'b1;
        end
      end
      itc_pkg::OP_TICK: begin
        irq_nxt = rsp[0].expire;
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      spk_r       <= 1'b0;
      refresh_r   <= 1'b0;
      gate2_r     <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        spk_r       <= spk_nxt;
        refresh_r   <= refresh_nxt;
        gate2_r     <= gate2_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= in_tdata[1:0];
      port_r <= in_tdata[9:2];
      data_r <= in_tdata[17:10];
      tick_r <= in_tdata[33:18];
    end
    if (advance) begin
      rd_r  <= rd_nxt;
      irq_r <= irq_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, err_r, irq_r, rd_r};

endmodule

FILE: tb/itc_timer_monitor.sv
// itc_timer_monitor: watches both stream channels of interval_timer_three_counter,
// predicts every result beat from its own copy of the timer state and compares
// depends on itc_pkg for port, operation and control word codes

module itc_timer_monitor
  import itc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     outstanding,
  output int                     irq_seen,
  output int                     fault_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       irq;
    logic       fault;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic [15:0] tmr_count     [SLOTS];
  logic [15:0] tmr_reload    [SLOTS];
  logic [15:0] tmr_snap      [SLOTS];
  logic [7:0]  tmr_low       [SLOTS];
  logic        tmr_rate      [SLOTS];
  logic        tmr_prog      [SLOTS];
  logic        tmr_run       [SLOTS];
  logic        tmr_out       [SLOTS];
  logic        tmr_gate      [SLOTS];
  logic        tmr_hi_next   [SLOTS];
  logic        tmr_snap_full [SLOTS];
  logic        tmr_snap_hi   [SLOTS];
  logic        spk_en;
  logic        refresh_bit;

  task automatic timer_step(input logic [1:0] op, input logic [7:0] port,
                            input logic [7:0] wdata, input logic [15:0] ticks,
                            output timer_result_t res);
    int unsigned id;
    logic [1:0]  rw;
    logic [2:0]  mode;
    logic [16:0] left;
    res = '0;
    case (op)
      OP_READ: begin
        if (port == PORT_C0 && tmr_snap_full[0]) begin
          if (!tmr_snap_hi[0]) begin
            tmr_snap_hi[0] = 1'b1;
            res.rd_byte = tmr_snap[0][7:0];
          end else begin
            tmr_snap_full[0] = 1'b0;
            tmr_snap_hi[0] = 1'b0;
            res.rd_byte = tmr_snap[0][15:8];
          end
        end else if (port == PORT_SYS) begin
          refresh_bit = ~refresh_bit;
          res.rd_byte = {2'b00, tmr_out[2], refresh_bit, 2'b00, spk_en, tmr_gate[2]};
        end else begin
          res.fault = 1'b1;
        end
      end
      OP_WRITE: begin
        if (port >= PORT_C0 && port < PORT_CTRL) begin
          id = port - PORT_C0;
          if (id >= NUM_COUNTERS || !tmr_prog[id]) begin
            res.fault = 1'b1;
          end else if (!tmr_hi_next[id]) begin
            tmr_low[id] = wdata;
            tmr_hi_next[id] = 1'b1;
          end else begin
            tmr_reload[id] = {wdata, tmr_low[id]};
            tmr_hi_next[id] = 1'b0;
            tmr_low[id] = '0;
            tmr_snap_full[id] = 1'b0;
            tmr_snap_hi[id] = 1'b0;
            if (!tmr_rate[id]) begin
              tmr_count[id] = tmr_reload[id];
              tmr_run[id] = 1'b1;
              if (tmr_gate[id]) tmr_out[id] = 1'b0;
            end else if (tmr_reload[id] == 16'd1) begin
              res.fault = 1'b1;
            end else if (tmr_gate[id] && !tmr_run[id]) begin
              tmr_count[id] = tmr_reload[id];
              tmr_run[id] = 1'b1;
              tmr_out[id] = 1'b1;
            end
          end
        end else if (port == PORT_CTRL) begin
          id = wdata[7:6];
          rw = wdata[5:4];
          mode = wdata[3:1];
          if (wdata[7:6] == ID_READBACK || mode > MODE_MAX || wdata[0] || id >= NUM_COUNTERS) begin
            res.fault = 1'b1;
          end else if (rw == RW_LATCH) begin
            if (tmr_snap_full[id]) begin
              res.fault = 1'b1;
            end else begin
              tmr_snap_full[id] = 1'b1;
              tmr_snap[id] = tmr_count[id];
              tmr_snap_hi[id] = 1'b0;
            end
          end else if (rw != RW_BOTH || (mode != MODE_ONESHOT && mode != MODE_RATE)) begin
            res.fault = 1'b1;
          end else begin
            tmr_rate[id] = (mode == MODE_RATE);
            tmr_prog[id] = 1'b1;
            tmr_low[id] = '0;
            tmr_hi_next[id] = 1'b0;
            tmr_out[id] = (mode == MODE_RATE);
          end
        end else if (port == PORT_SYS) begin
          spk_en = wdata[1];
          if (wdata[0] != tmr_gate[2]) begin
            tmr_gate[2] = wdata[0];
            res.fault = 1'b1;
          end
        end else begin
          res.fault = 1'b1;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (tmr_run[i]) begin
            left = (tmr_count[i] == 16'd0) ? 17'h10000 : {1'b0, tmr_count[i]};
            if (left > {1'b0, ticks}) begin
              tmr_count[i] = 16'(left - {1'b0, ticks});
            end else begin
              if (!tmr_rate[i]) begin
                tmr_count[i] = '0;
                tmr_run[i] = 1'b0;
                tmr_out[i] = 1'b1;
              end else begin
                tmr_count[i] = tmr_reload[i];
              end
              if (i == 0) res.irq = 1'b1;
            end
          end
        end
      end
      default: begin
        res.fault = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    timer_result_t want;
    timer_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tmr_count[i] = '0;
        tmr_reload[i] = '0;
        tmr_snap[i] = '0;
        tmr_low[i] = '0;
        tmr_rate[i] = 1'b0;
        tmr_prog[i] = 1'b0;
        tmr_run[i] = 1'b0;
        tmr_out[i] = 1'b0;
        tmr_gate[i] = (i != 2);
        tmr_hi_next[i] = 1'b0;
        tmr_snap_full[i] = 1'b0;
        tmr_snap_hi[i] = 1'b0;
      end
      spk_en = 1'b0;
      refresh_bit = 1'b0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        timer_step(in_tdata[1:0], in_tdata[9:2], in_tdata[17:10], in_tdata[33:18], want);
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.rd_byte = out_tdata[7:0];
        got.irq = out_tdata[8];
        got.fault = out_tdata[9];
        if (got.irq) irq_seen++;
        if (got.fault) fault_seen++;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing pending: read_data=%02h irq=%0b error=%0b",
                     $realtime, got.rd_byte, got.irq, got.fault);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.rd_byte !== want.rd_byte || got.irq !== want.irq ||
              got.fault !== want.fault) begin
            if (mismatches < 10)
              $display("%0t: mismatch read_data %02h/%02h irq %0b/%0b error %0b/%0b (exp/act)",
                       $realtime, want.rd_byte, got.rd_byte, want.irq, got.irq,
                       want.fault, got.fault);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for interval_timer_three_counter; directed port
// accesses, a back-pressure phase, then random timer programming, latches and ticks
// depends on itc_pkg, the block and itc_timer_monitor

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import itc_pkg::*;

  localparam int TOTAL_BEATS = 600;
  localparam int LONG_HOLD   = 300;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int  mismatches;
  int  outstanding;
  int  irq_seen;
  int  fault_seen;
  int  beats_sent;
  int  op_seen [4];
  bit  idle_on;
  bit  hold_request;

  interval_timer_three_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  itc_timer_monitor timer_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .irq_seen    (irq_seen),
    .fault_seen  (fault_seen)
  );

  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_access(input logic [1:0] op, input logic [7:0] port,
                             input logic [7:0] wdata, input logic [15:0] ticks);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, ticks, wdata, port, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    op_seen[op]++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h0001;
      3:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(2, 150));
    endcase
  endfunction

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 11))
      0:       return 16'hffff;
      1:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 80));
    endcase
  endfunction

  initial begin
    logic [1:0]  id;
    logic [2:0]  mode;
    logic [15:0] load;
    logic [7:0]  port;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    idle_on = 1'b0;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, empty latch, unsupported reads, unprogrammed counter
    send_access(OP_READ, PORT_SYS, 8'h00, 16'h0000);
    send_access(OP_READ, PORT_C0, 8'h00, 16'h0000);
    send_access(OP_READ, PORT_C1, 8'h00, 16'h0000);
    send_access(OP_READ, PORT_C2, 8'h00, 16'h0000);
    send_access(OP_WRITE, PORT_C2, 8'h05, 16'h0000);
    // counter 0 one-shot at count 0xffff, latch twice, read back, expire
    send_access(OP_WRITE, PORT_CTRL, {2'd0, RW_BOTH, MODE_ONESHOT, 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_C0, 8'hff, 16'h0000);
    send_access(OP_WRITE, PORT_C0, 8'hff, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd0, RW_LATCH, MODE_ONESHOT, 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd0, RW_LATCH, MODE_ONESHOT, 1'b0}, 16'h0000);
    send_access(OP_READ, PORT_C0, 8'h00, 16'h0000);
    send_access(OP_READ, PORT_C0, 8'h00, 16'h0000);
    send_access(OP_TICK, 8'h00, 8'h00, 16'hffff);
    // counter 1 rate generator: count of one, then count of zero
    send_access(OP_WRITE, PORT_CTRL, {2'd1, RW_BOTH, MODE_RATE, 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_C1, 8'h01, 16'h0000);
    send_access(OP_WRITE, PORT_C1, 8'h00, 16'h0000);
    send_access(OP_WRITE, PORT_C1, 8'h00, 16'h0000);
    send_access(OP_WRITE, PORT_C1, 8'h00, 16'h0000);
    // illegal control words: read-back, bcd, lsb-only, mode too high, mode 5
    send_access(OP_WRITE, PORT_CTRL, {ID_READBACK, RW_BOTH, MODE_ONESHOT, 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd0, RW_BOTH, MODE_ONESHOT, 1'b1}, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd0, 2'd1, MODE_ONESHOT, 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd0, RW_BOTH, 3'(MODE_MAX + 3'd1), 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd0, RW_BOTH, MODE_MAX, 1'b0}, 16'h0000);
    // gate 2 change, counter 2 expiry seen on port 0x61, stray port, bad operation
    send_access(OP_WRITE, PORT_SYS, 8'h03, 16'h0000);
    send_access(OP_WRITE, PORT_CTRL, {2'd2, RW_BOTH, MODE_ONESHOT, 1'b0}, 16'h0000);
    send_access(OP_WRITE, PORT_C2, 8'h03, 16'h0000);
    send_access(OP_WRITE, PORT_C2, 8'h00, 16'h0000);
    send_access(OP_TICK, 8'h00, 8'h00, 16'h0003);
    send_access(OP_READ, PORT_SYS, 8'h00, 16'h0000);
    send_access(OP_WRITE, 8'h80, 8'h00, 16'h0000);
    send_access(2'(OP_TICK + 2'd1), 8'hff, 8'hff, 16'hffff);

    // back-pressure: result side holds off while beats keep coming
    hold_request = 1'b1;
    repeat (40) send_access(OP_TICK, 8'h00, 8'h00, 16'($urandom_range(0, 20)));
    wait_drained();

    while (beats_sent < TOTAL_BEATS) begin
      idle_on = (beats_sent < TOTAL_BEATS - 100) && ((beats_sent / 100) % 2 == 0);
      id = 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0, 1: begin
          mode = $urandom_range(0, 1) ? MODE_RATE : MODE_ONESHOT;
          load = pick_count();
          send_access(OP_WRITE, PORT_CTRL, {id, RW_BOTH, mode, 1'b0}, 16'h0000);
          send_access(OP_WRITE, 8'(PORT_C0 + id), load[7:0], 16'h0000);
          if ($urandom_range(0, 7) != 0)
            send_access(OP_WRITE, 8'(PORT_C0 + id), load[15:8], 16'h0000);
        end
        2, 3, 4: begin
          send_access(OP_TICK, 8'(PORT_C0 + id), 8'($urandom_range(0, 255)), pick_ticks());
        end
        5, 6: begin
          send_access(OP_WRITE, PORT_CTRL,
                      {id, RW_LATCH, 3'($urandom_range(0, 5)), 1'b0}, 16'h0000);
          repeat ($urandom_range(0, 3)) send_access(OP_READ, PORT_C0, 8'h00, 16'h0000);
        end
        7: begin
          send_access(OP_WRITE, PORT_SYS, 8'($urandom_range(0, 255)), 16'h0000);
          send_access(OP_READ, PORT_SYS, 8'h00, 16'h0000);
        end
        8: begin
          port = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                      : 8'(PORT_C0 + $urandom_range(0, 3));
          if ($urandom_range(0, 4) == 0) port = PORT_SYS;
          send_access(2'($urandom_range(0, 3)), port, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
        end
        default: begin
          send_access(OP_WRITE, 8'(PORT_C0 + id), 8'($urandom_range(0, 255)), 16'h0000);
        end
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("covered %0d reads, %0d writes, %0d ticks and %0d invalid operations",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("checked %0d counter 0 expiries and %0d rejected accesses",
             irq_seen, fault_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/itc_pkg.sv
rtl/itc_counter.sv
rtl/interval_timer_three_counter.sv
tb/itc_timer_monitor.sv
tb/tb_top.sv
